[design/hpps_pkg.sv]
// shared types, pattern lengths and lookup functions for the haptic pulse sequencer
package hpps_pkg;

  parameter int unsigned GapCounterWidth = 16;
  parameter int unsigned ThrWidth        = 16;
  parameter int unsigned MsWidth         = 10;
  parameter int unsigned CmpWidth        = 32;

  parameter logic [ThrWidth-1:0] ThrReset = 16'd151;

  parameter logic [MsWidth-1:0] LenAutoOn    = 10'd100;
  parameter logic [MsWidth-1:0] LenMicroOn   = 10'd50;
  parameter logic [MsWidth-1:0] LenMicroOff  = 10'd20;
  parameter logic [MsWidth-1:0] LenShortOn   = 10'd120;
  parameter logic [MsWidth-1:0] LenLongOn    = 10'd1000;
  parameter logic [MsWidth-1:0] LenDblOn0    = 10'd200;
  parameter logic [MsWidth-1:0] LenDblOff0   = 10'd100;
  parameter logic [MsWidth-1:0] LenDblOn1    = 10'd400;

  typedef enum logic {
    ReqTick    = 1'b0,
    ReqCommand = 1'b1
  } req_e;

  // pattern codes; auto resolves to micro or the plain 100 ms pattern
  typedef enum logic [2:0] {
    PatAuto   = 3'd0,
    PatMicro  = 3'd1,
    PatShort  = 3'd2,
    PatLong   = 3'd3,
    PatDouble = 3'd4
  } pat_e;

  typedef struct packed {
    logic                       playing;
    pat_e                       pattern;
    logic                       seg;
    logic                       off_phase;
    logic [MsWidth-1:0]         ms_rem;
    logic [GapCounterWidth-1:0] gap;
    logic                       seen;
  } seq_state_t;

  typedef struct packed {
    logic motor_on;
    logic busy;
    logic dropped;
  } seq_result_t;

  function automatic logic [MsWidth-1:0] on_len(pat_e pat, logic seg);
    logic [MsWidth-1:0] len;
    case (pat)
      PatAuto:   len = LenAutoOn;
      PatMicro:  len = LenMicroOn;
      PatShort:  len = LenShortOn;
      PatLong:   len = LenLongOn;
      PatDouble: len = seg ? LenDblOn1 : LenDblOn0;
      default:   len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [MsWidth-1:0] off_len(pat_e pat, logic seg);
    logic [MsWidth-1:0] len;
    len = '0;
    if (!seg && pat == PatMicro) len = LenMicroOff;
    if (!seg && pat == PatDouble) len = LenDblOff0;
    return len;
  endfunction

endpackage

[design/haptic_pulse_pattern_sequencer.sv]
// top level of the haptic pulse pattern sequencer: state and result registers
// usage:
//   input channel (in_valid_i / in_ready_o) carries one request per transfer:
//   req_type_i = 0 is a one millisecond tick, 1 is a pulse command whose
//   pulse_kind_i selects auto, micro, short, long or double (5..7 only restart
//   the gap timer). each accepted request yields exactly one result transfer on
//   the output channel (out_valid_o / out_ready_i) with motor_on_o, busy_res_o
//   and dropped_o. commands arriving while a pattern plays are dropped and flagged.
//   the result is registered and is valid the cycle after the input transfer.
//   one request per cycle; the sequencer state and a single result
//   register are updated in the same cycle, so in_ready_o stays high as long
//   as the result register is empty or being drained in that cycle.
//   when the receiver stalls, the pending result holds and in_ready_o drops
//   until it is taken; nothing is lost.
//   cfg_we_i / cfg_wdata_i write the auto gap threshold; write only
//   while no result is pending.
//   reset (rst_ni low, async): no pattern playing, gap counter zero, no
//   command seen, threshold back to 151 ms, output channel empty.
module haptic_pulse_pattern_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_we_i,
  input  logic [hpps_pkg::ThrWidth-1:0]  cfg_wdata_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [2:0]                     pulse_kind_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           motor_on_o,
  output logic                           busy_res_o,
  output logic                           dropped_o
);

  hpps_pkg::seq_state_t          state_q, state_d;
  hpps_pkg::seq_result_t         result_q, result_d;
  logic [hpps_pkg::ThrWidth-1:0] thr_q;
  logic                          out_valid_q;
  logic                          in_xfer;

  // result register is free when empty or drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  hpps_step u_step (
    .state_i      (state_q),
    .req_type_i   (req_type_i),
    .pulse_kind_i (pulse_kind_i),
    .threshold_i  (thr_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hpps_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // sequencer state advances only on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motor_on_o  = result_q.motor_on;
  assign busy_res_o  = result_q.busy;
  assign dropped_o   = result_q.dropped;

endmodule

[design/hpps_step.sv]
// next-state and result logic for one tick or command
module hpps_step (
  input  hpps_pkg::seq_state_t             state_i,
  input  logic                             req_type_i,
  input  logic [2:0]                       pulse_kind_i,
  input  logic [hpps_pkg::ThrWidth-1:0]    threshold_i,
  output hpps_pkg::seq_state_t             state_o,
  output hpps_pkg::seq_result_t            result_o
);

  logic [hpps_pkg::GapCounterWidth-1:0] gap_seen;
  logic [hpps_pkg::MsWidth-1:0]         off_cur;
  logic                                 dropped;
  logic                                 gap_below;

  assign off_cur  = hpps_pkg::off_len(state_i.pattern, state_i.seg);
  assign gap_seen = state_i.seen ? state_i.gap : '0;
  assign gap_below = hpps_pkg::CmpWidth'(gap_seen) < hpps_pkg::CmpWidth'(threshold_i);

  always_comb begin
    state_o = state_i;
    dropped = 1'b0;
    if (req_type_i == hpps_pkg::ReqTick) begin
      if (state_i.gap != '1) state_o.gap = state_i.gap + 1'b1;
      if (state_i.playing) begin
        if (state_i.ms_rem > hpps_pkg::MsWidth'(1)) begin
          state_o.ms_rem = state_i.ms_rem - 1'b1;
        end else if (!state_i.off_phase && off_cur != '0) begin
          state_o.off_phase = 1'b1;
          state_o.ms_rem    = off_cur;
        end else if (!state_i.seg && state_i.pattern == hpps_pkg::PatDouble) begin
          state_o.seg       = 1'b1;
          state_o.off_phase = 1'b0;
          state_o.ms_rem    = hpps_pkg::on_len(state_i.pattern, 1'b1);
        end else begin
          state_o.playing   = 1'b0;
          state_o.off_phase = 1'b0;
          state_o.seg       = 1'b0;
          state_o.ms_rem    = '0;
        end
      end
    end else if (state_i.playing) begin
      dropped = 1'b1;
    end else begin
      state_o.seen = 1'b1;
      state_o.gap  = '0;
      if (pulse_kind_i <= 3'(hpps_pkg::PatDouble)) begin
        if (pulse_kind_i == 3'(hpps_pkg::PatAuto)) begin
          state_o.pattern = gap_below ? hpps_pkg::PatMicro : hpps_pkg::PatAuto;
        end else begin
          state_o.pattern = hpps_pkg::pat_e'(pulse_kind_i);
        end
        state_o.playing   = 1'b1;
        state_o.seg       = 1'b0;
        state_o.off_phase = 1'b0;
        state_o.ms_rem    = hpps_pkg::on_len(state_o.pattern, 1'b0);
      end
    end
  end

  assign result_o.motor_on = state_o.playing && !state_o.off_phase;
  assign result_o.busy     = state_o.playing;
  assign result_o.dropped  = dropped;

endmodule

[design/hpps_checker.sv]
// port-level checker for the haptic pulse sequencer and its bind
module hpps_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           motor_on_o,
  input logic                           busy_res_o,
  input logic                           dropped_o
);

  // a dropped command means a pattern was and still is playing
  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> busy_res_o)
    else $error("dropped without busy");

  // motor can only run while a pattern plays
  a_motor_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_on_o |-> busy_res_o)
    else $error("motor on while idle");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // every input transfer yields a result the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after input transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_on_o)
      && $stable(busy_res_o) && $stable(dropped_o))
    else $error("stalled result changed");

endmodule

bind haptic_pulse_pattern_sequencer hpps_checker u_hpps_checker (.*);

[dv/haptic_pulse_pattern_sequencer_tb.sv]
// testbench for the haptic pulse pattern sequencer: random handshakes, predicted results
`timescale 1ns / 1ps

module haptic_pulse_pattern_sequencer_tb;

  // pulse kinds above the double pattern carry no pattern
  localparam logic [2:0] KindMax = 3'd7;

  typedef struct packed {
    hpps_pkg::req_e req;
    logic [2:0]     kind;
  } seq_req_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block ports; the inputs that the bench drives are known from time zero
  logic                          cfg_we = 1'b0;
  logic [hpps_pkg::ThrWidth-1:0] cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  hpps_pkg::req_e                req_type = hpps_pkg::ReqTick;
  logic [2:0]                    pulse_kind = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          motor_on;
  logic                          busy_res;
  logic                          dropped;

  // requests waiting for the driver and results the sequencer still owes
  seq_req_t              pending_reqs[$];
  hpps_pkg::seq_result_t owed_results[$];

  // idle percentages for each side, changed per phase
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 84;
  int unsigned mismatches = 0;

  // predictor state: mirrors the sequencer after every accepted request
  logic                                 playing_q = 1'b0;
  hpps_pkg::pat_e                       pat_q = hpps_pkg::PatAuto;
  logic                                 seg_q = 1'b0;
  logic                                 off_q = 1'b0;
  logic [hpps_pkg::MsWidth-1:0]         ms_q = '0;
  logic [hpps_pkg::GapCounterWidth-1:0] gap_q = '0;
  logic                                 seen_q = 1'b0;
  logic [hpps_pkg::ThrWidth-1:0]        thr_q = hpps_pkg::ThrReset;

  haptic_pulse_pattern_sequencer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .pulse_kind_i (pulse_kind),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .motor_on_o   (motor_on),
    .busy_res_o   (busy_res),
    .dropped_o    (dropped)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // length in ms of one phase of a pattern; an off phase of zero means none
  function automatic logic [hpps_pkg::MsWidth-1:0] phase_ms(hpps_pkg::pat_e pat, logic seg,
                                                            logic off);
    if (off) begin
      if (seg) return '0;
      if (pat == hpps_pkg::PatMicro) return hpps_pkg::LenMicroOff;
      if (pat == hpps_pkg::PatDouble) return hpps_pkg::LenDblOff0;
      return '0;
    end
    if (pat == hpps_pkg::PatDouble) return seg ? hpps_pkg::LenDblOn1 : hpps_pkg::LenDblOn0;
    if (pat == hpps_pkg::PatMicro) return hpps_pkg::LenMicroOn;
    if (pat == hpps_pkg::PatShort) return hpps_pkg::LenShortOn;
    if (pat == hpps_pkg::PatLong) return hpps_pkg::LenLongOn;
    return hpps_pkg::LenAutoOn;
  endfunction

  // move the playing pattern forward by one millisecond
  task automatic tick_pattern();
    if (ms_q > 1) begin
      ms_q = ms_q - 1'b1;
    end else if (!off_q && phase_ms(pat_q, seg_q, 1'b1) != 0) begin
      // on phase over, enter its off gap
      off_q = 1'b1;
      ms_q  = phase_ms(pat_q, seg_q, 1'b1);
    end else if (pat_q == hpps_pkg::PatDouble && !seg_q) begin
      // second burst of the double pattern
      seg_q = 1'b1;
      off_q = 1'b0;
      ms_q  = phase_ms(pat_q, 1'b1, 1'b0);
    end else begin
      playing_q = 1'b0;
      off_q     = 1'b0;
      seg_q     = 1'b0;
      ms_q      = '0;
    end
  endtask

  // apply one request to the predictor and return the result it should give
  task automatic sequence_step(input seq_req_t r, output hpps_pkg::seq_result_t res);
    logic [hpps_pkg::GapCounterWidth-1:0] gap_seen;
    logic                                 drop;
    drop = 1'b0;
    if (r.req == hpps_pkg::ReqTick) begin
      if (gap_q != '1) gap_q = gap_q + 1'b1;
      if (playing_q) tick_pattern();
    end else if (playing_q) begin
      // busy: the command is lost and the gap timer keeps running
      drop = 1'b1;
    end else begin
      // the very first command sees a gap of zero
      gap_seen = seen_q ? gap_q : '0;
      seen_q   = 1'b1;
      gap_q    = '0;
      if (r.kind <= hpps_pkg::PatDouble) begin
        pat_q = hpps_pkg::pat_e'(r.kind);
        if (r.kind == hpps_pkg::PatAuto)
          pat_q = (gap_seen < thr_q) ? hpps_pkg::PatMicro : hpps_pkg::PatAuto;
        playing_q = 1'b1;
        seg_q     = 1'b0;
        off_q     = 1'b0;
        ms_q      = phase_ms(pat_q, 1'b0, 1'b0);
      end
    end
    res.motor_on = playing_q && !off_q;
    res.busy     = playing_q;
    res.dropped  = drop;
  endtask

  task automatic report_mismatch(string what, logic want, logic got);
    $display("%0t mismatch on %s: expected %0b, got %0b", $realtime, what, want, got);
    mismatches++;
  endtask

  // driver: presents the next pending request, holds it until the transfer
  always @(posedge clk or negedge rst_n) begin : req_driver
    seq_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      req_type   <= hpps_pkg::ReqTick;
      pulse_kind <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        req_type   <= nxt.req;
        pulse_kind <= nxt.kind;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check a result transfer first, then predict for a request transfer
  always @(posedge clk) begin : result_monitor
    hpps_pkg::seq_result_t want;
    seq_req_t              taken;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result transfer", 1'b0, 1'b1);
        end else begin
          want = owed_results.pop_front();
          if (motor_on !== want.motor_on) report_mismatch("motor_on", want.motor_on, motor_on);
          if (busy_res !== want.busy) report_mismatch("busy_res", want.busy, busy_res);
          if (dropped !== want.dropped) report_mismatch("dropped", want.dropped, dropped);
        end
      end
      if (in_valid && in_ready) begin
        taken.req  = req_type;
        taken.kind = pulse_kind;
        sequence_step(taken, want);
        owed_results.push_back(want);
      end
    end
  end

  task automatic push_ticks(int n);
    seq_req_t r;
    repeat (n) begin
      r.req  = hpps_pkg::ReqTick;
      r.kind = 3'($urandom_range(0, KindMax));
      pending_reqs.push_back(r);
    end
  endtask

  task automatic push_command(logic [2:0] kind);
    seq_req_t r;
    r.req  = hpps_pkg::ReqCommand;
    r.kind = kind;
    pending_reqs.push_back(r);
  endtask

  // sampled at the falling edge so that all driver updates have settled
  task automatic wait_until_quiet();
    while (pending_reqs.size() != 0 || in_valid || out_valid || owed_results.size() != 0)
      @(negedge clk);
  endtask

  // threshold writes happen only with nothing in flight
  task automatic write_threshold(logic [hpps_pkg::ThrWidth-1:0] value);
    wait_until_quiet();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q = value;
  endtask

  // ticks a pattern needs to finish, auto taken as its plain 100 ms form
  function automatic int pattern_span(int kind);
    case (kind)
      hpps_pkg::PatAuto:   return hpps_pkg::LenAutoOn;
      hpps_pkg::PatMicro:  return hpps_pkg::LenMicroOn + hpps_pkg::LenMicroOff;
      hpps_pkg::PatShort:  return hpps_pkg::LenShortOn;
      hpps_pkg::PatLong:   return hpps_pkg::LenLongOn;
      hpps_pkg::PatDouble: return hpps_pkg::LenDblOn0 + hpps_pkg::LenDblOff0 + hpps_pkg::LenDblOn1;
      default:             return 0;
    endcase
  endfunction

  // one command followed by ticks; tick counts land near pattern ends or the
  // auto threshold or are random, with a few stray commands mixed in as noise;
  // never more than room items in total
  task automatic random_episode(input int room, output int n_items);
    int kind;
    int span;
    int pick;
    kind = $urandom_range(0, KindMax);
    // long patterns eat many ticks, so keep them rare
    if ((kind == hpps_pkg::PatLong || kind == hpps_pkg::PatDouble) && $urandom_range(0, 3) != 0)
      kind = $urandom_range(hpps_pkg::PatAuto, hpps_pkg::PatShort);
    pick = $urandom_range(0, 9);
    if (pick < 4) span = pattern_span(kind) + $urandom_range(0, 4) - 2;
    else if (pick < 6 && thr_q < 400) span = int'(thr_q) + $urandom_range(0, 2) - 1;
    else if (pick < 8) span = $urandom_range(0, 150);
    else span = $urandom_range(0, 4);
    if (span < 0) span = 0;
    if (span > room - 1) span = room - 1;
    push_command(3'(kind));
    for (int i = 0; i < span; i++) begin
      if ($urandom_range(0, 29) == 0) push_command(3'($urandom_range(0, KindMax)));
      else push_ticks(1);
    end
    n_items = span + 1;
  endtask

  task automatic random_phase(int budget);
    int sent;
    int n;
    int episodes;
    sent = 0;
    episodes = 0;
    while (sent < budget) begin
      random_episode(budget - sent, n);
      sent += n;
      episodes++;
      // now and then let the sequencer drain completely before going on
      if (episodes % 12 == 0) wait_until_quiet();
    end
  endtask

  // stimulus: directed opening, then random phases under several thresholds
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles 24 %, receiver 84 %; threshold at its reset value
    send_idle_pct = 24;
    recv_idle_pct = 84;
    push_ticks(3);
    // first command sees a zero gap, so auto gives micro
    push_command(hpps_pkg::PatAuto);
    // command while busy is dropped and keeps the gap timer running
    push_command(hpps_pkg::PatShort);
    push_ticks(pattern_span(hpps_pkg::PatMicro));
    // bring the gap to exactly the threshold: plain 100 ms
    push_ticks(int'(hpps_pkg::ThrReset) - pattern_span(hpps_pkg::PatMicro));
    push_command(hpps_pkg::PatAuto);
    push_ticks(pattern_span(hpps_pkg::PatAuto));
    // codes without a pattern only restart the gap timer
    for (int k = hpps_pkg::PatDouble + 1; k <= KindMax; k++) push_command(3'(k));
    // double pattern with a dropped command inside its off gap
    push_command(hpps_pkg::PatDouble);
    push_ticks(250);
    push_command(KindMax);
    push_ticks(pattern_span(hpps_pkg::PatDouble) - 250);

    // sender idles 84 %, receiver 24 %
    write_threshold(hpps_pkg::ThrWidth'($urandom_range(20, 300)));
    send_idle_pct = 84;
    recv_idle_pct = 24;
    random_phase(120);

    // no idling from here on; auto never picks micro, then nearly always does
    write_threshold('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(60);

    write_threshold('1);
    random_phase(60);

    wait_until_quiet();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // timeout well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
